// ===== design/bounded_deque_with_indexed_read_macros.svh =====
// Assertion macros shared by the deque checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BOUNDED_DEQUE_WITH_INDEXED_READ_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_READ_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BDQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdq check failed");

// Next-cycle implication, quiet during reset.
`define BDQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdq check failed");

`endif

// ===== design/bdq_pkg.sv =====
// Shared types, sizes and helpers of the bounded deque.
// No dependencies; used by bdq_ifs, bdq_ctrl, the top level and bdq_checker.
package bdq_pkg;

   localparam int CAPACITY = 64;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int ACTION_W = 3;
   localparam int IDX_W    = 6;
   localparam int OUT_COUNT_W = 7;
   localparam int CMP_W    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [DATA_W-1:0]  word_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_READ       = 3'd4
   } action_type;

   // One access to the entry store.
   typedef struct packed {
      logic     en;
      logic     we;
      ptr_type  addr;
      word_type wdata;
   } mem_req_type;

   // What the response stage needs about a request in flight.
   typedef struct packed {
      logic      ok;
      logic      use_data;
      count_type count;
   } meta_type;

   // Slot k places behind base, wrapping at CAPACITY.
   function automatic ptr_type slot_after(input ptr_type base, input ptr_type k);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, k};
      if (sum >= (PTR_W + 1)'(CAPACITY)) begin
         sum = sum - (PTR_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// ===== design/bdq_ifs.sv =====
// Request and response channel interfaces of the bounded deque.
// Depends on bdq_pkg for field widths.
interface bdq_req_if import bdq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic signed [DATA_W-1:0] value;
   logic [IDX_W-1:0]    index;

   modport source (output valid, action, value, index, input ready);
   modport sink   (input valid, action, value, index, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic signed [DATA_W-1:0] data;
   logic [OUT_COUNT_W-1:0] count;

   modport source (output valid, ok, data, count, input ready);
   modport sink   (input valid, ok, data, count, output ready);
endinterface

// ===== design/bdq_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module bdq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
      // read data holds when the port is idle
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/bdq_ctrl.sv =====
// Deque control: decodes requests, keeps front pointer and fill count,
// drives the entry store and the in-flight stage. Depends on bdq_pkg.
module bdq_ctrl import bdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  word_type            req_value,
   input  logic [IDX_W-1:0]    req_index,
   input  logic                advance,
   output mem_req_type         mem_req,
   output logic                s1_valid,
   output meta_type            s1_meta
);

   ptr_type   front_ff,    front_in;
   count_type fill_ff,     fill_in;
   logic      s1_valid_ff, s1_valid_in;
   meta_type  meta_ff,     meta_in;

   logic    accept;
   logic    not_full, not_empty, idx_ok;
   ptr_type fill_ptr, front_dec;

   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign not_full  = (fill_ff != COUNT_W'(CAPACITY));
   assign not_empty = (fill_ff != '0);
   assign idx_ok    = (CMP_W'(req_index) < CMP_W'(fill_ff));
   assign fill_ptr  = fill_ff[PTR_W-1:0];
   assign front_dec = (front_ff == '0) ? PTR_W'(CAPACITY - 1) : front_ff - 1'b1;

   always_comb begin
      front_in          = front_ff;
      fill_in           = fill_ff;
      mem_req.en        = 1'b0;
      mem_req.we        = 1'b0;
      mem_req.addr      = front_ff;
      mem_req.wdata     = req_value;
      meta_in.ok        = 1'b0;
      meta_in.use_data  = 1'b0;
      if (accept) begin
         case (req_action)
            ACT_PUSH_BACK: begin
               if (not_full) begin
                  mem_req.en   = 1'b1;
                  mem_req.we   = 1'b1;
                  mem_req.addr = slot_after(front_ff, fill_ptr);
                  fill_in      = fill_ff + 1'b1;
                  meta_in.ok   = 1'b1;
               end
            end
            ACT_PUSH_FRONT: begin
               if (not_full) begin
                  mem_req.en   = 1'b1;
                  mem_req.we   = 1'b1;
                  mem_req.addr = front_dec;
                  front_in     = front_dec;
                  fill_in      = fill_ff + 1'b1;
                  meta_in.ok   = 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (not_empty) begin
                  mem_req.en       = 1'b1;
                  mem_req.addr     = front_ff;
                  front_in         = slot_after(front_ff, PTR_W'(1));
                  fill_in          = fill_ff - 1'b1;
                  meta_in.ok       = 1'b1;
                  meta_in.use_data = 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (not_empty) begin
                  mem_req.en       = 1'b1;
                  mem_req.addr     = slot_after(front_ff, fill_ptr - 1'b1);
                  fill_in          = fill_ff - 1'b1;
                  meta_in.ok       = 1'b1;
                  meta_in.use_data = 1'b1;
               end
            end
            ACT_READ: begin
               if (not_empty && idx_ok) begin
                  mem_req.en       = 1'b1;
                  mem_req.addr     = slot_after(front_ff, req_index[PTR_W-1:0]);
                  meta_in.ok       = 1'b1;
                  meta_in.use_data = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      meta_in.count = fill_in;
      s1_valid_in   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         front_ff    <= front_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_meta  = meta_ff;

endmodule

// ===== design/bounded_deque_with_indexed_read.sv =====
// Bounded double-ended queue of signed 32-bit values with indexed read.
// Channels: req_chan (sink) carries action, value and index; rsp_chan
// (source) returns ok, data and count. A request moves on a clock edge where
// valid and ready are both high; likewise a response.
// Actions: push back, push front, pop front, pop back, read at index from
// the front. Codes 5..7 change nothing and answer ok = 0.
// Flow: the edge that takes a request also does the entry store access and
// loads the in-flight stage; the response register is loaded from that stage
// on an edge where the register is empty or its response is being taken.
// Throughput: one request per cycle while responses are taken; the single store
// port does one read or one write per request, and pointer and count update at
// acceptance, so a request may follow the one before it directly.
// Stall: while the response register is full and not taken, one more request
// can be held in flight; req ready then drops until the response leaves.
// Reset (synchronous, active high): deque empty, front slot zero, no
// response pending. The entry store is not cleared; only written slots are
// ever read. Depends on bdq_pkg, bdq_ifs, bdq_ram and bdq_ctrl.
module bounded_deque_with_indexed_read import bdq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_chan,
   bdq_rsp_if.source rsp_chan
);

   mem_req_type mem_req;
   word_type    rdata;
   logic        s1_valid;
   meta_type    s1_meta;
   logic        advance;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff;
   word_type               rsp_data_ff;
   logic [OUT_COUNT_W-1:0] rsp_count_ff;

   // response register may be (re)loaded when empty or being taken
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_action (req_chan.action),
      .req_value  (req_chan.value),
      .req_index  (req_chan.index),
      .advance    (advance),
      .mem_req    (mem_req),
      .s1_valid   (s1_valid),
      .s1_meta    (s1_meta)
   );

   // entry store; a write and a later read of the same slot fall on
   // different edges, so no forwarding is needed
   bdq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock (clock),
      .en    (mem_req.en),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (rdata)
   );

   always_comb begin
      if (s1_valid && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: data is zero for pushes and failures
   always_ff @(posedge clock) begin
      if (s1_valid && advance) begin
         rsp_ok_ff    <= s1_meta.ok;
         rsp_data_ff  <= s1_meta.use_data ? rdata : '0;
         rsp_count_ff <= OUT_COUNT_W'(s1_meta.count);
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ok    = rsp_ok_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign rsp_chan.count = rsp_count_ff;

endmodule

// ===== design/bdq_checker.sv =====
// Port-level checks of the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_indexed_read_macros.svh.
`include "bounded_deque_with_indexed_read_macros.svh"

module bdq_checker import bdq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_ok,
   input logic [DATA_W-1:0]      rsp_data,
   input logic [OUT_COUNT_W-1:0] rsp_count
);

   // requests taken but not yet answered
   logic [1:0] pend_ff, pend_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `BDQ_ASSERT_NOW(a_no_orphan_rsp, clock, reset, rsp_valid, pend_ff != 2'd0)
   `BDQ_ASSERT_NOW(a_bounded_flight, clock, reset, 1'b1, pend_ff <= 2'd2)
   `BDQ_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_data == '0)
   `BDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count) && $stable(rsp_data) && $stable(rsp_ok))

endmodule

bind bounded_deque_with_indexed_read bdq_checker u_bdq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_ok    (rsp_chan.ok),
   .rsp_data  (rsp_chan.data),
   .rsp_count (rsp_chan.count)
);

// ===== test/deque_response_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the bounded deque: mirrors the deque, predicts each
// response from the requests taken and compares it field by field.
// Depends on bdq_pkg and the channel interfaces in bdq_ifs.
module deque_response_checker import bdq_pkg::*; (
   input  logic clock,
   input  logic reset,
   bdq_req_if   req_mon,
   bdq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   awaited_responses,
   output int   entries_held
);

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] data;
      logic [OUT_COUNT_W-1:0]   count;
   } deque_answer_type;

   deque_answer_type         expected_answers[$];
   logic signed [DATA_W-1:0] mirror_slots [CAPACITY];
   int unsigned              mirror_front;
   int unsigned              mirror_fill;

   // Applies one request to the mirror and returns the answer it should give.
   function automatic deque_answer_type apply_request(
      input logic [ACTION_W-1:0]    act,
      input logic signed [DATA_W-1:0] val,
      input logic [IDX_W-1:0]       idx
   );
      deque_answer_type ans;
      int unsigned      slot;
      ans = '0;
      case (act)
         ACT_PUSH_BACK: begin
            if (mirror_fill < CAPACITY) begin
               slot = (mirror_front + mirror_fill) % CAPACITY;
               mirror_slots[slot] = val;
               mirror_fill++;
               ans.ok = 1'b1;
            end
         end
         ACT_PUSH_FRONT: begin
            if (mirror_fill < CAPACITY) begin
               mirror_front = (mirror_front == 0) ? CAPACITY - 1 : mirror_front - 1;
               mirror_slots[mirror_front] = val;
               mirror_fill++;
               ans.ok = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (mirror_fill > 0) begin
               ans.data = mirror_slots[mirror_front];
               mirror_front = (mirror_front + 1) % CAPACITY;
               mirror_fill--;
               ans.ok = 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (mirror_fill > 0) begin
               slot = (mirror_front + mirror_fill - 1) % CAPACITY;
               ans.data = mirror_slots[slot];
               mirror_fill--;
               ans.ok = 1'b1;
            end
         end
         ACT_READ: begin
            if (idx < mirror_fill) begin
               slot = (mirror_front + idx) % CAPACITY;
               ans.data = mirror_slots[slot];
               ans.ok = 1'b1;
            end
         end
         default: ;  // unused codes leave everything alone
      endcase
      ans.count = OUT_COUNT_W'(mirror_fill);
      return ans;
   endfunction

   always @(posedge clock) begin
      deque_answer_type seen;
      deque_answer_type want;
      if (reset) begin
         expected_answers.delete();
         mirror_front = 0;
         mirror_fill  = 0;
      end else begin
         // a response never belongs to the request taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{ok: rsp_mon.ok, data: rsp_mon.data, count: rsp_mon.count};
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected response ok=%0b data=%0d count=%0d",
                        $time, seen.ok, seen.data, seen.count);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               if (seen.ok !== want.ok) begin
                  $display("%0t: ok expected %0b got %0b", $time, want.ok, seen.ok);
                  mismatch_count++;
               end
               if (seen.data !== want.data) begin
                  $display("%0t: data expected %0d got %0d", $time, want.data, seen.data);
                  mismatch_count++;
               end
               if (seen.count !== want.count) begin
                  $display("%0t: count expected %0d got %0d",
                           $time, want.count, seen.count);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_answers.push_back(apply_request(req_mon.action, req_mon.value,
                                                     req_mon.index));
         end
      end
      entries_held      = mirror_fill;
      awaited_responses = expected_answers.size();
   end

endmodule

// ===== test/tb_bounded_deque_with_indexed_read.sv =====
`timescale 1ns / 1ps
// Testbench top for the bounded deque: drives requests, paces responses and
// gives the verdict. Depends on bdq_pkg, bdq_ifs, the deque and
// deque_response_checker.
module tb_bounded_deque_with_indexed_read;
   import bdq_pkg::*;

   localparam int GAP_MAX         = 16;
   localparam int WATCHDOG_LIMIT  = 2000;  // idle edges before giving up
   localparam int RANDOM_REQUESTS = 1150;
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall
   localparam int FLOOD_REQUESTS  = 12;    // well beyond what the deque can hold in flight
   localparam int SETTLE_CYCLES   = 10;
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;

   typedef enum int { PHASE_FILL, PHASE_DRAIN, PHASE_MIXED } phase_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   awaited_responses;
   int   entries_held;
   int   idle_cycles = 0;
   int   rsp_hold_cycles = 0;      // set by stimulus, consumed by the receiver
   int   sender_burst_left = 0;
   int   receiver_burst_left = 0;

   bdq_req_if req_chan();
   bdq_rsp_if rsp_chan();

   bounded_deque_with_indexed_read i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_response_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .mismatch_count    (mismatch_count),
      .awaited_responses (awaited_responses),
      .entries_held      (entries_held)
   );

   always #5 clock = ~clock;

   // Idle cycles before the next handshake; now and then a burst with none.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Push payloads lean on the extremes now and then.
   function automatic logic signed [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Leaves the caller on a falling edge, ready to present a request.
   task automatic idle_before_request(input bit back_to_back);
      int gap;
      gap = back_to_back ? 0 : draw_gap(sender_burst_left);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
   endtask

   // Presents one request and returns on the edge that takes it.
   task automatic hand_over(input logic [ACTION_W-1:0] act,
                            input logic signed [DATA_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.value  <= val;
      req_chan.index  <= idx;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_fixed(input logic [ACTION_W-1:0] act,
                             input logic signed [DATA_W-1:0] val,
                             input logic [IDX_W-1:0] idx);
      idle_before_request(1'b0);
      hand_over(act, val, idx);
   endtask

   // Random request shaped by the phase: fill phases push, drain phases pop,
   // mixed phases take anything. Reads mostly hit a valid position.
   task automatic send_drawn(input phase_kind_type kind, input bit back_to_back,
                             inout int counted);
      logic [ACTION_W-1:0] act;
      logic [IDX_W-1:0]    idx;
      int                  pick;
      idle_before_request(back_to_back);
      pick = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL:
            if (pick < 85) act = pick[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            else           act = ACT_READ;
         PHASE_DRAIN:
            if (pick < 85) act = pick[0] ? ACT_POP_FRONT : ACT_POP_BACK;
            else           act = ACT_READ;
         default:
            if (pick < 3)
               act = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, 2**ACTION_W - 1));
            else
               act = ACTION_W'($urandom_range(ACT_PUSH_BACK, ACT_READ));
      endcase
      // entries_held is settled by the falling edge we are on
      if (entries_held > 0 && $urandom_range(0, 4) != 0)
         idx = IDX_W'($urandom_range(0, entries_held - 1));
      else
         idx = IDX_W'($urandom());
      hand_over(act, draw_value(), idx);
      if (act <= ACT_READ) counted++;
   endtask

   // Stops offering and waits until every predicted response is back.
   task automatic wait_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_responses != 0) @(negedge clock);
   endtask

   // Response side: random back-pressure, plus a long hold-off on request.
   initial begin : receiver
      int gap;
      int hold;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            repeat (hold) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
         gap = draw_gap(receiver_burst_left);
         repeat (gap) begin
            @(negedge clock);
            rsp_chan.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Watchdog: too long without any handshake means the deque has hung.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int             counted;
      int             phase_no;
      int             run_length;
      phase_kind_type kind;
      req_chan.valid  = 1'b0;
      req_chan.action = '0;
      req_chan.value  = '0;
      req_chan.index  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty deque first - every pop and read must fail.
      send_fixed(ACT_POP_FRONT, '0, '0);
      send_fixed(ACT_POP_BACK, '0, '0);
      send_fixed(ACT_READ, '0, '0);
      // unused codes change nothing
      for (int c = ACT_FIRST_UNUSED; c < 2**ACTION_W; c++)
         send_fixed(ACTION_W'(c), '1, '1);
      // payload extremes at both ends; push front from slot zero wraps
      send_fixed(ACT_PUSH_FRONT, 32'sh8000_0000, '0);
      send_fixed(ACT_PUSH_BACK, 32'sh7FFF_FFFF, '1);
      send_fixed(ACT_PUSH_BACK, '0, '0);
      send_fixed(ACT_PUSH_FRONT, '1, '0);
      send_fixed(ACT_READ, '1, 6'd0);
      send_fixed(ACT_READ, '0, 6'd3);
      send_fixed(ACT_READ, '0, 6'd4);   // index equal to count
      send_fixed(ACT_READ, '0, '1);     // index far past count
      send_fixed(ACT_POP_BACK, '0, '0);
      send_fixed(ACT_POP_FRONT, '0, '0);
      send_fixed(ACT_READ, '0, 6'd1);
      send_fixed(ACT_POP_FRONT, '0, '0);
      send_fixed(ACT_POP_BACK, '0, '0);
      send_fixed(ACT_POP_FRONT, '0, '0);  // empty again
      send_fixed(ACT_PUSH_BACK, 32'sh5A5A_A5A5, '0);
      send_fixed(ACT_PUSH_FRONT, 32'sh0123_4567, '0);
      send_fixed(ACT_READ, '0, 6'd1);
      send_fixed(ACT_POP_BACK, '0, '0);

      // Random phases. The first one, and some later ones, start with a
      // flood against a stalled receiver followed by a full drain.
      counted  = 0;
      phase_no = 0;
      while (counted < RANDOM_REQUESTS) begin
         kind = phase_kind_type'($urandom_range(PHASE_FILL, PHASE_MIXED));
         if (phase_no == 0 || $urandom_range(0, 9) == 0) begin
            wait_until_drained();
            rsp_hold_cycles = HOLD_OFF_CYCLES;
            repeat (FLOOD_REQUESTS) send_drawn(PHASE_FILL, 1'b1, counted);
            wait_until_drained();
         end
         run_length = $urandom_range(20, 90);
         repeat (run_length) send_drawn(kind, 1'b0, counted);
         phase_no++;
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
